@@ sv/bgnt_pkg.sv @@
// Package for the binary grid neighbor threshold pass.
// Holds sizes, register indexes, input op codes, the result word type and helpers.
// No dependencies; every other file imports it.
package bgnt_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int MIN_DIM    = 3;

	localparam int DIM_W  = 8;
	localparam int THR_W  = 4;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 2;
	localparam int DATA_W = 8;
	localparam int OCOL_W = 7;
	localparam int OROW_W = 7;

	localparam logic [DIM_W-1:0] GRID_WIDTH_RST      = DIM_W'(74);
	localparam logic [DIM_W-1:0] GRID_HEIGHT_RST     = DIM_W'(46);
	localparam logic [THR_W-1:0] BIRTH_THRESHOLD_RST = THR_W'(4);

	typedef enum logic [IDX_W-1:0] {
		REG_GRID_WIDTH      = 2'd0,
		REG_GRID_HEIGHT     = 2'd1,
		REG_BIRTH_THRESHOLD = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_CELL  = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef struct packed {
		logic [OCOL_W-1:0] out_col;
		logic [OROW_W-1:0] out_row;
		logic              new_value;
		logic              frame_last;
	} res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		if (v < DIM_W'(MIN_DIM)) begin
			r = DIM_W'(MIN_DIM);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [1:0] bits3(input logic [2:0] x);
		return 2'({1'b0, x[0]} + {1'b0, x[1]} + {1'b0, x[2]});
	endfunction

endpackage

@@ sv/bgnt_cell_if.sv @@
// Input channel interface: one grid cell or drain word per handshake.
// Depends on bgnt_pkg.
interface bgnt_cell_if import bgnt_pkg::*; ();
	logic valid;
	logic ready;
	logic op;
	logic cell_value;

	modport source (output valid, op, cell_value, input ready);
	modport sink   (input valid, op, cell_value, output ready);
endinterface

@@ sv/bgnt_res_if.sv @@
// Result channel interface: one smoothed cell word per handshake.
// Depends on bgnt_pkg.
interface bgnt_res_if import bgnt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OCOL_W-1:0] out_col;
	logic [OROW_W-1:0] out_row;
	logic              new_value;
	logic              frame_last;

	modport source (output valid, out_col, out_row, new_value, frame_last, input ready);
	modport sink   (input valid, out_col, out_row, new_value, frame_last, output ready);
endinterface

@@ sv/bgnt_cfg_if.sv @@
// Configuration write channel interface: register index and write data.
// Depends on bgnt_pkg.
interface bgnt_cfg_if import bgnt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/binary_grid_neighbor_threshold_pass.sv @@
// Top level of the binary grid neighbor threshold pass.
// Depends on bgnt_pkg and the interfaces bgnt_cell_if, bgnt_res_if, bgnt_cfg_if.
//
// One smoothing pass of a cellular automaton over a binary grid fed in raster
// order, one cell word per cycle while the result buffer has room. Each result
// gives the new value of a cell (1 when at least birth_threshold of its eight
// neighbors are set, cells off the grid counting as zero) and appears width+1
// words after that cell, so width+1 drain words must follow the last cell;
// frame_last marks the final cell, after which the next word starts a new
// grid. The neighbor count sits between the registered line-store read and a
// two-word result buffer, and the line store is one 2-bit wide memory with one
// read and one write port. A write to a defined register restarts the frame.
module binary_grid_neighbor_threshold_pass import bgnt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bgnt_cell_if.sink    cells,
	bgnt_res_if.source   results,
	bgnt_cfg_if.sink     cfg
);

	logic [DIM_W-1:0] grid_width_q;
	logic [DIM_W-1:0] grid_height_q;
	logic [THR_W-1:0] birth_threshold_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [8:0]       win_q;

	logic [1:0] line_mem [MAX_WIDTH];
	logic [1:0] rd_q;

	res_t       slot0_q, slot1_q;
	logic [1:0] fill_q;

	logic cfg_wr, cfg_hit, acc, pop;
	logic [DIM_W-1:0] w, h, ocol, orow, col_inc;
	logic [ROW_W-1:0] row_inc, row_next;
	logic [COL_W-1:0] col_next, rd_addr;
	logic             v, have, last;
	logic [2:0]       newcol, lcol, ccol, rcol;
	logic [8:0]       win_next;
	logic [CNT_W-1:0] cnt;
	res_t             res;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign cfg_hit   = cfg_wr && (cfg.index == REG_GRID_WIDTH || cfg.index == REG_GRID_HEIGHT
		|| cfg.index == REG_BIRTH_THRESHOLD);

	assign cells.ready = (fill_q != 2'd2);
	assign acc         = cells.valid && cells.ready;

	assign results.valid      = (fill_q != 2'd0);
	assign results.out_col    = slot0_q.out_col;
	assign results.out_row    = slot0_q.out_row;
	assign results.new_value  = slot0_q.new_value;
	assign results.frame_last = slot0_q.frame_last;
	assign pop                = results.valid && results.ready;

	always_comb begin
		w = clamp_dim(grid_width_q, DIM_W'(MAX_WIDTH));
		h = clamp_dim(grid_height_q, DIM_W'(MAX_HEIGHT));
		v = (cells.op == OP_CELL) && (DIM_W'(row_q) < h) && cells.cell_value;
		newcol   = {v, rd_q[0], rd_q[1]};
		win_next = {win_q[5:0], newcol};
		if (col_q == '0) begin
			have = (row_q >= ROW_W'(2));
			orow = DIM_W'(row_q - ROW_W'(2));
			ocol = w - DIM_W'(1);
			lcol = win_q[5:3];
			ccol = win_q[2:0];
			rcol = 3'b000;
		end else begin
			have = (row_q >= ROW_W'(1));
			orow = DIM_W'(row_q - ROW_W'(1));
			ocol = DIM_W'(col_q) - DIM_W'(1);
			lcol = win_next[8:6];
			ccol = win_next[5:3];
			rcol = win_next[2:0];
		end
		if (orow == '0) begin
			lcol = lcol & 3'b110;
			ccol = ccol & 3'b110;
			rcol = rcol & 3'b110;
		end
		if (orow == h - DIM_W'(1)) begin
			lcol = lcol & 3'b011;
			ccol = ccol & 3'b011;
			rcol = rcol & 3'b011;
		end
		if (ocol == '0) begin
			lcol = 3'b000;
		end
		if (ocol == w - DIM_W'(1)) begin
			rcol = 3'b000;
		end
		cnt  = CNT_W'(bits3(lcol)) + CNT_W'(bits3(rcol)) + CNT_W'(ccol[0]) + CNT_W'(ccol[2]);
		last = have && (orow == h - DIM_W'(1)) && (ocol == w - DIM_W'(1));

		res.out_col    = ocol[OCOL_W-1:0];
		res.out_row    = orow[OROW_W-1:0];
		res.new_value  = ({1'b0, cnt} >= {1'b0, birth_threshold_q});
		res.frame_last = last;

		col_inc = DIM_W'(col_q) + DIM_W'(1);
		row_inc = row_q + ROW_W'(1);
		if (last) begin
			col_next = '0;
			row_next = '0;
		end else if (col_inc >= w) begin
			col_next = '0;
			row_next = row_inc;
		end else begin
			col_next = col_inc[COL_W-1:0];
			row_next = row_q;
		end

		if (cfg_hit) begin
			rd_addr = '0;
		end else if (acc) begin
			rd_addr = col_next;
		end else begin
			rd_addr = col_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			line_mem[col_q] <= {rd_q[0], v};
		end
		rd_q <= line_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q      <= GRID_WIDTH_RST;
			grid_height_q     <= GRID_HEIGHT_RST;
			birth_threshold_q <= BIRTH_THRESHOLD_RST;
			col_q             <= '0;
			row_q             <= '0;
			win_q             <= '0;
		end else if (cfg_hit) begin
			unique case (cfg.index)
				REG_GRID_WIDTH:      grid_width_q      <= cfg.data;
				REG_GRID_HEIGHT:     grid_height_q     <= cfg.data;
				REG_BIRTH_THRESHOLD: birth_threshold_q <= cfg.data[THR_W-1:0];
				default:             ;
			endcase
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
		end else if (acc) begin
			col_q <= col_next;
			row_q <= row_next;
			win_q <= last ? 9'd0 : win_next;
		end
	end

	// two-word result buffer: slot0 is the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_q + 2'(acc && have) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && have && (fill_q == 2'd0 || (fill_q == 2'd1 && pop))) begin
			slot0_q <= res;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
		if (acc && have && fill_q != 2'd0 && !(fill_q == 2'd1 && pop)) begin
			slot1_q <= res;
		end
	end

endmodule
